FILE: rtl/tsia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Time-slot interval allocator package
// Shared codes, widths and the sequencer state type.
// ----------------------------------------------------------------------------
package tsia_pkg;

   localparam int unsigned TIME_W      = 32;
   localparam int unsigned SESSION_W   = 8;
   localparam int unsigned FREE_W      = 5;
   localparam int unsigned SEARCH_STEP = 50;

   // Numerator of the step divide: run length plus rounding, below 2^33.
   localparam int unsigned DIV_W     = TIME_W + 1;
   localparam int unsigned REM_W     = $clog2(SEARCH_STEP);

   // floor(n / 50) = (floor(n / 2) * STEP_RECIP) >> STEP_RECIP_SHIFT for n below 2^33
   localparam logic [TIME_W-1:0] STEP_RECIP       = 32'h51EB_851F;
   localparam int unsigned       STEP_RECIP_SHIFT = 35;

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_QUERY   = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_HELD      = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_EVAL,
      ST_DIV,
      ST_RESP
   } state_type;

endpackage : tsia_pkg
`default_nettype wire

FILE: rtl/tsia_div50.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Step divider
// Divide of a 33-bit value by the search step through a reciprocal multiply:
// start registers the numerator, then quotient and done are registered together.
// ----------------------------------------------------------------------------
module tsia_div50
   import tsia_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] num,
   output logic                  done,
   output logic [DIV_W-1:0]      quot,
   output logic [REM_W-1:0]      rem
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_W-1:0]      num_ff, num_in;
   logic [DIV_W-1:0]      quot_ff, quot_in;
   logic [2*TIME_W-1:0]   product;

   always_comb begin
      // halve first, then divide by 25 with a 32 x 32 multiply
      product = (2*TIME_W)'(num_ff[DIV_W-1:1]) * (2*TIME_W)'(STEP_RECIP);
      busy_in = 1'b0;
      done_in = 1'b0;
      num_in  = num_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         num_in  = num;
      end else if (busy_ff) begin
         quot_in = DIV_W'(product[2*TIME_W-1:STEP_RECIP_SHIFT]);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   // remainder is below the step, so the low bits of num - 50 * quot suffice
   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = num_ff[REM_W-1:0] - quot_ff[REM_W-1:0] * REM_W'(SEARCH_STEP);

endmodule : tsia_div50
`default_nettype wire

FILE: rtl/time_slot_interval_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Time-slot interval allocator
// Slot table with owner lookup, wrapping-interval start search and release.
// ----------------------------------------------------------------------------
//
//  channel | ports                      | payload, low bit first
//  --------+----------------------------+-------------------------------------
//  req     | req_tvalid/tready/tdata/   | tuser: func[1:0]
//          | tuser                      | tdata: session[7:0], length[39:8]
//  rsp     | rsp_tvalid/tready/tdata    | tdata: status[1:0], granted_start
//          |                            | [33:2], free_entries[38:34], pad
//  csr     | csr_valid/ready/data       | search_origin[31:0], always ready
//
//  Release, status query and the early allocate answers (already held, table
//  full) go straight from accept to the response register. An allocate that
//  searches passes, per candidate start, through setup, a scan of every table
//  entry and evaluate; each rejected candidate adds a jump divide (reciprocal
//  multiply) in the step divider before the next one. The search time depends
//  on the entry scan and the number of rejected candidates.
//  Reset is synchronous and clears the valid bits, search origin and
//  sequencer. One request is in flight at a time: req_tready is low from
//  accept until the response has been taken, and a stalled response holds.
// ----------------------------------------------------------------------------
module time_slot_interval_allocator
   import tsia_pkg::*;
#(
   parameter int unsigned SLOT_ENTRIES = 8
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request: session[7:0], length[39:8]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   // request kind: func[1:0]
   input  wire logic [1:0]  req_tuser,
   // response: status[1:0], granted_start[33:2], free_entries[38:34], zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,
   // search origin write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   localparam int unsigned IDX_W = (SLOT_ENTRIES > 1) ? $clog2(SLOT_ENTRIES) : 1;

   // control
   state_type              state_ff, state_in;
   logic [SLOT_ENTRIES-1:0] valid_ff, valid_in;
   logic [TIME_W-1:0]      origin_ff;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   // search datapath
   logic [TIME_W-1:0]      s_ff, s_in;
   logic [TIME_W-1:0]      k_ff, k_in;
   logic [TIME_W-1:0]      u_ff, u_in;
   logic [TIME_W:0]        wrap_ff, wrap_in;
   logic [TIME_W:0]        run_ff, run_in;
   logic [DIV_W-1:0]       num_ff, num_in;
   logic [SESSION_W-1:0]   session_ff, session_in;
   logic [TIME_W-1:0]      len_ff, len_in;
   status_type             status_ff, status_in;
   logic [TIME_W-1:0]      grant_ff, grant_in;

   // slot table; entries are only read where the valid bit is set
   logic [SESSION_W-1:0]   owner_ff [SLOT_ENTRIES];
   logic [TIME_W-1:0]      start_ff [SLOT_ENTRIES];
   logic [TIME_W-1:0]      end_ff   [SLOT_ENTRIES];
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_idx;

   // lookups
   logic                   own_hit;
   logic [IDX_W-1:0]       own_idx;
   logic                   free_hit;
   logic [IDX_W-1:0]       free_idx;
   logic [FREE_W-1:0]      free_cnt;

   // scan compare
   logic                   hit;
   logic [TIME_W:0]        cand_end;

   // divider
   logic                   div_start;
   logic                   div_done;
   logic [DIV_W-1:0]       div_quot;
   logic [REM_W-1:0]       div_rem;

   func_type               req_func;
   logic [SESSION_W-1:0]   req_session;
   logic [TIME_W-1:0]      req_length;

   assign req_func    = func_type'(req_tuser);
   assign req_session = req_tdata[SESSION_W-1:0];
   assign req_length  = req_tdata[SESSION_W +: TIME_W];

   // owner lookup, first free entry and free count over the valid bits
   always_comb begin
      own_hit  = 1'b0;
      own_idx  = '0;
      free_hit = 1'b0;
      free_idx = '0;
      free_cnt = '0;
      for (int i = SLOT_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && owner_ff[i] == req_session) begin
            own_hit = 1'b1;
            own_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_hit = 1'b1;
            free_idx = IDX_W'(i);
            free_cnt = free_cnt + FREE_W'(1);
         end
      end
   end

   // overlap of the current candidate with the scanned entry, and the end of
   // the run of candidates that overlap it (the lesser of entry end and the
   // point where the candidate's own end wraps)
   always_comb begin
      hit      = valid_ff[idx_ff] && (s_ff < end_ff[idx_ff]) && (u_ff > start_ff[idx_ff]);
      cand_end = ({1'b0, end_ff[idx_ff]} < wrap_ff) ? {1'b0, end_ff[idx_ff]} : wrap_ff;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      idx_in     = idx_ff;
      s_in       = s_ff;
      k_in       = k_ff;
      u_in       = u_ff;
      wrap_in    = wrap_ff;
      run_in     = run_ff;
      num_in     = num_ff;
      session_in = session_ff;
      len_in     = len_ff;
      status_in  = status_ff;
      grant_in   = grant_ff;
      wr_en      = 1'b0;
      wr_idx     = free_idx;
      div_start  = 1'b0;
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_RESP);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               session_in = req_session;
               len_in     = req_length;
               grant_in   = '0;
               status_in  = STAT_DONE;
               state_in   = ST_RESP;
               case (req_func)
                  FUNC_ALLOC: begin
                     if (own_hit) begin
                        status_in = STAT_HELD;
                     end else if (!free_hit) begin
                        status_in = STAT_FULL;
                     end else begin
                        s_in     = origin_ff;
                        k_in     = '0;
                        state_in = ST_SETUP;
                     end
                  end
                  FUNC_RELEASE: begin
                     if (own_hit) begin
                        valid_in[own_idx] = 1'b0;
                     end else begin
                        status_in = STAT_NOT_FOUND;
                     end
                  end
                  default: begin
                     // status query; the unused code behaves the same
                  end
               endcase
            end
         end
         ST_SETUP: begin
            // per-candidate terms: wrapped end and the wrap point
            u_in     = s_ff + len_ff;
            wrap_in  = {1'b0, s_ff} + {1'b1, TIME_W'(0)} - {1'b0, s_ff + len_ff};
            run_in   = '0;
            idx_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit && cand_end > run_ff) begin
               run_in = cand_end;
            end
            if (idx_ff == IDX_W'(SLOT_ENTRIES - 1)) begin
               state_in = ST_EVAL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_EVAL: begin
            if (run_ff == '0) begin
               // candidate clear of every active entry: grant it
               wr_en            = 1'b1;
               valid_in[wr_idx] = 1'b1;
               grant_in         = s_ff;
               status_in        = STAT_DONE;
               state_in         = ST_RESP;
            end else begin
               // jump past the run: ceil((run_end - s) / step) steps
               num_in    = run_ff - {1'b0, s_ff} + DIV_W'(SEARCH_STEP - 1);
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               k_in = k_ff + div_quot[TIME_W-1:0];
               s_in = s_ff + num_ff[TIME_W-1:0] - TIME_W'(div_rem);
               if (k_in[TIME_W-1]) begin
                  // one full period of candidates without a free start
                  status_in = STAT_FULL;
                  grant_in  = '0;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         origin_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_valid) begin
            origin_ff <= csr_data;
         end
      end
      idx_ff     <= idx_in;
      s_ff       <= s_in;
      k_ff       <= k_in;
      u_ff       <= u_in;
      wrap_ff    <= wrap_in;
      run_ff     <= run_in;
      num_ff     <= num_in;
      session_ff <= session_in;
      len_ff     <= len_in;
      status_ff  <= status_in;
      grant_ff   <= grant_in;
   end

   // table write on grant; the stored end is start plus length, wrapped
   always_ff @(posedge clock) begin
      if (wr_en) begin
         owner_ff[wr_idx] <= session_ff;
         start_ff[wr_idx] <= s_ff;
         end_ff[wr_idx]   <= s_ff + len_ff;
      end
   end

   tsia_div50 u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_in),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // free count follows the valid bits, which hold while the response waits
   assign rsp_tdata = {1'b0, free_cnt, grant_ff, status_ff};
   assign csr_ready = 1'b1;

endmodule : time_slot_interval_allocator
`default_nettype wire

FILE: tb/time_slot_interval_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Time-slot interval allocator testbench
// Runs a table of directed requests, then random phases under several search
// origins. Responses are compared field by field against an in-bench model of
// the slot table and its wrapping start search.
// ----------------------------------------------------------------------------
module time_slot_interval_allocator_test
   import tsia_pkg::*;
();

   localparam int unsigned     TABLE_DEPTH   = 8;
   localparam int unsigned     RANDOM_PHASES = 7;
   localparam int unsigned     PHASE_ITEMS   = 82;
   localparam int unsigned     HOLD_OFF      = 400;
   localparam int unsigned     HOLD_AT_REPLY = 120;
   // Unused function code; the block answers it like a status query.
   localparam logic [1:0]      FUNC_SPARE    = 2'd3;
   localparam longint unsigned TIME_MASK     = 64'hFFFF_FFFF;
   localparam longint unsigned TIME_SPAN     = 64'h1_0000_0000;
   // Candidate starts repeat after this many steps of SEARCH_STEP.
   localparam longint unsigned SEARCH_PERIOD = 64'h8000_0000;

   typedef struct packed {
      status_type  status;
      logic [31:0] granted_start;
      logic [4:0]  free_entries;
   } slot_reply_type;

   // One line of the directed table. Where typed is set, reply is the answer
   // to expect; otherwise the slot model supplies it.
   typedef struct packed {
      logic [1:0]     func;
      logic [7:0]     session;
      logic [31:0]    length;
      logic           typed;
      slot_reply_type reply;
   } slot_request_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // session[7:0], length[39:8]
   logic [1:0]  req_tuser;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // status[1:0], granted_start[33:2], free_entries[38:34]
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   // Model of the slot table and the search origin register.
   logic [31:0] origin_time;
   logic        slot_active [TABLE_DEPTH];
   logic [7:0]  slot_owner  [TABLE_DEPTH];
   logic [31:0] slot_begin  [TABLE_DEPTH];
   logic [31:0] slot_span   [TABLE_DEPTH];

   slot_reply_type pending_replies [$];
   int unsigned mismatch_count = 0;
   int unsigned reply_count    = 0;
   // Set for phases in which neither side draws random idle cycles.
   bit          steady_run     = 1'b0;

   always #5 clock = ~clock;

   time_slot_interval_allocator #(
      .SLOT_ENTRIES (TABLE_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // -------------------------------------------------------------------------
   // Slot model
   // -------------------------------------------------------------------------

   function automatic int owner_slot(input logic [7:0] session);
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (slot_active[i] && slot_owner[i] == session)
            return i;
      return -1;
   endfunction

   function automatic logic [4:0] free_slot_count();
      logic [4:0] count;
      count = '0;
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (!slot_active[i])
            count++;
      return count;
   endfunction

   // Walk the candidates origin + 50*k. A rejected candidate skips every
   // following candidate that would hit the same blocking entries: jump to
   // the end of the blocked run, rounded up to the next step.
   function automatic bit search_start_time(input logic [31:0] span,
                                            output logic [31:0] start);
      longint unsigned k;
      longint unsigned cand;
      longint unsigned tail;
      longint unsigned run_end;
      longint unsigned s_lo;
      longint unsigned s_hi;
      longint unsigned wrap_end;
      longint unsigned reach;
      k = 0;
      while (k < SEARCH_PERIOD) begin
         cand    = (longint'(origin_time) + SEARCH_STEP * k) & TIME_MASK;
         tail    = (cand + span) & TIME_MASK;
         run_end = 0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_active[i]) begin
               s_lo = slot_begin[i];
               s_hi = (s_lo + slot_span[i]) & TIME_MASK;
               // Plain unsigned compares on the wrapped ends.
               if (cand < s_hi && tail > s_lo) begin
                  wrap_end = cand + TIME_SPAN - tail;
                  reach    = (s_hi < wrap_end) ? s_hi : wrap_end;
                  if (reach > run_end)
                     run_end = reach;
               end
            end
         end
         if (run_end == 0) begin
            start = cand[31:0];
            return 1'b1;
         end
         k += (run_end - cand + SEARCH_STEP - 1) / SEARCH_STEP;
      end
      start = '0;
      return 1'b0;
   endfunction

   // Apply one request to the model and return the response it must produce.
   function automatic slot_reply_type predict_reply(input logic [1:0]  func,
                                                    input logic [7:0]  session,
                                                    input logic [31:0] length);
      slot_reply_type reply;
      int             held;
      int             free_idx;
      logic [31:0]    start;
      reply    = '{STAT_DONE, 32'd0, 5'd0};
      held     = owner_slot(session);
      free_idx = -1;
      case (func)
         FUNC_ALLOC: begin
            // Lowest inactive entry takes the grant.
            for (int i = TABLE_DEPTH - 1; i >= 0; i--)
               if (!slot_active[i])
                  free_idx = i;
            // Ownership is checked ahead of the full table and the search.
            if (held >= 0)
               reply.status = STAT_HELD;
            else if (free_idx < 0 || !search_start_time(length, start))
               reply.status = STAT_FULL;
            else begin
               slot_active[free_idx] = 1'b1;
               slot_owner[free_idx]  = session;
               slot_begin[free_idx]  = start;
               slot_span[free_idx]   = length;
               reply.granted_start   = start;
            end
         end
         FUNC_RELEASE: begin
            if (held < 0)
               reply.status = STAT_NOT_FOUND;
            else
               slot_active[held] = 1'b0;
         end
         default: ;  // status query, spare code included
      endcase
      reply.free_entries = free_slot_count();
      return reply;
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offer one request and hold it until taken. Valid stays high across
   // back-to-back requests; within a phase it drops only when a gap is drawn.
   task automatic offer_request(input logic [1:0]     func,
                                input logic [7:0]     session,
                                input logic [31:0]    length,
                                input logic           typed,
                                input slot_reply_type typed_reply);
      int unsigned    gap;
      slot_reply_type predicted;
      gap = steady_run ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {length, session};
      do @(posedge clock); while (!req_tready);
      // Advance the model in acceptance order; keep its answer unless the
      // table row spells the answer out.
      predicted = predict_reply(func, session, length);
      pending_replies.push_back(typed ? typed_reply : predicted);
   endtask

   // Write the search origin; only called while nothing is in flight.
   task automatic write_origin(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      origin_time  = value;
   endtask

   initial begin
      slot_request_row_type directed_rows [$];
      logic [31:0]          origin_plan   [RANDOM_PHASES];
      logic [1:0]           func;
      logic [7:0]           session;
      logic [31:0]          length;
      int unsigned          pick;

      req_tvalid  = 1'b0;
      req_tuser   = FUNC_QUERY;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      origin_time = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_active[i] = 1'b0;
         slot_owner[i]  = '0;
         slot_begin[i]  = '0;
         slot_span[i]   = '0;
      end

      // Origin stays at its reset value of zero for the whole table.
      directed_rows = '{
         // empty table answers a query with every entry free
         '{FUNC_QUERY,   8'd0,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd8}},
         // first grant lands on time zero with zero length
         '{FUNC_ALLOC,   8'd0,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd7}},
         // a zero-length entry blocks nothing, so zero is granted again
         '{FUNC_ALLOC,   8'd255, 32'd100,        1'b1, '{STAT_DONE, 32'd0, 5'd6}},
         '{FUNC_ALLOC,   8'd1,   32'd100,        1'b0, '{STAT_DONE, 32'd0, 5'd0}},
         '{FUNC_SPARE,   8'd0,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd5}},
         '{FUNC_RELEASE, 8'd0,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd6}},
         '{FUNC_RELEASE, 8'd0,   32'd0,          1'b1, '{STAT_NOT_FOUND, 32'd0, 5'd6}},
         // fill the table through the jump search
         '{FUNC_ALLOC,   8'd2,   32'h8000_0000,  1'b0, '{STAT_DONE, 32'd0, 5'd0}},
         '{FUNC_ALLOC,   8'd3,   32'd7,          1'b0, '{STAT_DONE, 32'd0, 5'd0}},
         '{FUNC_ALLOC,   8'd4,   32'd1,          1'b0, '{STAT_DONE, 32'd0, 5'd0}},
         '{FUNC_ALLOC,   8'd5,   32'd50,         1'b0, '{STAT_DONE, 32'd0, 5'd0}},
         '{FUNC_ALLOC,   8'd6,   32'd0,          1'b0, '{STAT_DONE, 32'd0, 5'd0}},
         '{FUNC_ALLOC,   8'd7,   32'd3,          1'b0, '{STAT_DONE, 32'd0, 5'd0}},
         '{FUNC_ALLOC,   8'd8,   32'd10,         1'b1, '{STAT_FULL, 32'd0, 5'd0}},
         // an owner is reported even when the table is full
         '{FUNC_ALLOC,   8'd1,   32'd10,         1'b1, '{STAT_HELD, 32'd0, 5'd0}},
         '{FUNC_RELEASE, 8'd255, 32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd1}},
         '{FUNC_RELEASE, 8'd1,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd2}},
         '{FUNC_RELEASE, 8'd2,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd3}},
         '{FUNC_RELEASE, 8'd3,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd4}},
         '{FUNC_RELEASE, 8'd4,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd5}},
         '{FUNC_RELEASE, 8'd5,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd6}},
         '{FUNC_RELEASE, 8'd6,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd7}},
         '{FUNC_RELEASE, 8'd7,   32'd0,          1'b1, '{STAT_DONE, 32'd0, 5'd8}},
         // one entry spanning almost all of time leaves no even start free
         '{FUNC_ALLOC,   8'd9,   32'hFFFF_FFFF,  1'b1, '{STAT_DONE, 32'd0, 5'd7}},
         '{FUNC_ALLOC,   8'd10,  32'd1,          1'b1, '{STAT_FULL, 32'd0, 5'd7}}
      };

      // Extremes of the origin, a value just below the wrap, odd values.
      origin_plan = '{32'hFFFF_FFFF, 32'hFFFF_FFCE, $urandom, 32'h0000_0001,
                      32'h8000_0000, $urandom, 32'h0000_0000};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         offer_request(directed_rows[r].func, directed_rows[r].session,
                       directed_rows[r].length, directed_rows[r].typed,
                       directed_rows[r].reply);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // Drain before touching the origin register.
         req_tvalid <= 1'b0;
         while (pending_replies.size() != 0) @(posedge clock);
         write_origin(origin_plan[phase]);
         steady_run = phase[0];
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            func = (pick < 45) ? FUNC_ALLOC   :
                   (pick < 80) ? FUNC_RELEASE :
                   (pick < 95) ? FUNC_QUERY   : FUNC_SPARE;
            // A small session pool keeps owners, repeats and full tables common.
            session = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, 11));
            pick = $urandom_range(0, 9);
            if (pick < 6)
               length = $urandom_range(0, 400);
            else if (pick < 8)
               length = $urandom_range(0, 100000);
            else if (pick < 9)
               length = $urandom;
            else begin
               case ($urandom_range(0, 2))
                  0:       length = 32'd0;
                  1:       length = 32'h8000_0000;
                  default: length = 32'hFFFF_FFFF;
               endcase
            end
            offer_request(func, session, length, 1'b0, '{STAT_DONE, 32'd0, 5'd0});
         end
      end

      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      // Catch any stray response after the last expected one.
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------

   initial begin
      int unsigned    hold;
      slot_reply_type want;
      logic [1:0]     got_status;
      logic [31:0]    got_start;
      logic [4:0]     got_free;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         hold = steady_run ? 0 : $urandom_range(0, 3);
         // Hold off once for a long stretch so the request side backs up.
         if (reply_count == HOLD_AT_REPLY)
            hold = HOLD_OFF;
         if (hold != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         reply_count++;
         got_status = rsp_tdata[1:0];
         got_start  = rsp_tdata[33:2];
         got_free   = rsp_tdata[38:34];
         if (pending_replies.size() == 0) begin
            $error("response with no request outstanding: status %0d start %0h free %0d",
                   got_status, got_start, got_free);
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            if (got_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got_status);
               mismatch_count++;
            end
            if (got_start !== want.granted_start) begin
               $error("granted_start: expected %0h, got %0h", want.granted_start,
                      got_start);
               mismatch_count++;
            end
            if (got_free !== want.free_entries) begin
               $error("free_entries: expected %0d, got %0d", want.free_entries,
                      got_free);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: a stuck handshake ends the run as a failure.
   initial begin
      #500_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
